// ===== rtl/core/fbm_pkg.sv =====
package fbm_pkg;

	localparam int MAX_OCTAVES_DEF = 8;
	localparam int ANGLE_BITS_DEF  = 10;
	localparam int DOT_W           = 20;
	localparam int SUM_W           = DOT_W + 2;

	localparam logic [31:0] HASH_MUL_A = 32'd3284157443;
	localparam logic [31:0] HASH_MUL_B = 32'd1911520717;
	localparam logic signed [17:0] CONTRAST_Q16 = 18'sd78643;
	localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

	localparam logic [24:0] SCALE_RECIP_RST  = 25'd16777216;
	localparam logic [30:0] COORD_OFFSET_RST = 31'd32768;
	localparam logic [31:0] SEED_RST         = 32'd1;
	localparam logic [3:0]  OCTAVE_COUNT_RST = 4'd1;

	typedef enum logic [1:0] {
		REG_SCALE_RECIP  = 2'd0,
		REG_COORD_OFFSET = 2'd1,
		REG_SEED         = 2'd2,
		REG_OCTAVE_COUNT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [24:0] scale_recip;
		logic [30:0] coord_offset;
		logic [31:0] seed;
	} cfg_t;

	typedef struct packed {
		logic signed [17:0] dx;
		logic signed [17:0] dy;
	} dxy_t;

	typedef struct packed {
		logic [16:0] t;
		logic [16:0] t2;
		logic [15:0] inner;
		logic [16:0] mid;
		logic        neg;
	} sin_t;

	function automatic logic [31:0] rot16(input logic [31:0] v);
		return {v[15:0], v[31:16]};
	endfunction

	function automatic logic [16:0] sq_step(input logic [16:0] t);
		logic [33:0] p;
		p = {17'd0, t} * {17'd0, t};
		return p[32:16];
	endfunction

	function automatic logic [15:0] inner_step(input logic [16:0] t2);
		logic [29:0] p;
		p = {13'd0, t2} * 30'd4926;
		return 16'd42334 - {3'd0, p[28:16]};
	endfunction

	function automatic logic [16:0] mid_step(input logic [16:0] t2, input logic [15:0] inner);
		logic [32:0] p;
		p = {16'd0, t2} * {17'd0, inner};
		return 17'd102944 - {1'b0, p[31:16]};
	endfunction

	function automatic logic signed [15:0] grad_step(input sin_t s);
		logic [33:0] p;
		logic [18:0] r;
		logic [16:0] q;
		logic [15:0] v;
		p = {17'd0, s.t} * {17'd0, s.mid};
		r = {1'b0, p[33:16]} + 19'd2;
		q = r[18:2];
		v = (q > 17'd16384) ? 16'd16384 : q[15:0];
		return s.neg ? -$signed(v) : $signed(v);
	endfunction

	function automatic logic [15:0] fade_sq(input logic [15:0] w);
		logic [31:0] p;
		p = {16'd0, w} * {16'd0, w};
		return p[31:16];
	endfunction

	function automatic logic [16:0] fade_mul(input logic [15:0] w2, input logic [15:0] w);
		logic [17:0] k;
		logic [33:0] p;
		k = 18'd196608 - {1'b0, w, 1'b0};
		p = {18'd0, w2} * {16'd0, k};
		return p[32:16];
	endfunction

	function automatic logic signed [DOT_W-1:0] blend(input logic signed [DOT_W-1:0] a,
			input logic signed [DOT_W-1:0] b, input logic [16:0] s);
		logic signed [DOT_W:0] d;
		logic signed [DOT_W+18:0] p;
		d = $signed({b[DOT_W-1], b}) - $signed({a[DOT_W-1], a});
		p = d * $signed({1'b0, s});
		return a + p[DOT_W+15:16];
	endfunction

endpackage

// ===== rtl/core/fbm_corner.sv =====
module fbm_corner
	import fbm_pkg::*;
#(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF,
	parameter bit OX = 1'b0,
	parameter bit OY = 1'b0
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [31:0]             seed,
	input  logic [31:0]             x0,
	input  logic [31:0]             y0,
	input  logic [15:0]             fx,
	input  logic [15:0]             fy,
	output logic signed [DOT_W-1:0] dot
);

	localparam logic [31:0] ANGLE_MASK = ~(32'hFFFF_FFFF >> ANGLE_BITS);

	logic [31:0] a1_s3, cy_s3, a1_s4, b_s4, a3_s5;
	dxy_t        d_s3, d_s4, d_s5, d_s6, d_s7, d_s8, d_s9;
	sin_t        ps_s6, pc_s6, ps_s7, pc_s7, ps_s8, pc_s8;
	logic signed [15:0] gs_s9, gc_s9;
	logic signed [DOT_W-1:0] dot_s10;

	logic [31:0] cx, p;
	logic [16:0] r, rc;
	dxy_t        d_in;
	sin_t        ns, nc;
	sin_t        ns7, nc7, ns8, nc8;
	logic signed [34:0] pa, pb, dsum;

	always_comb begin
		cx = x0 + {31'd0, OX};
		d_in.dx = OX ? $signed({2'b11, fx}) : $signed({2'b00, fx});
		d_in.dy = OY ? $signed({2'b11, fy}) : $signed({2'b00, fy});
		p = a3_s5 & ANGLE_MASK;
		r = {1'b0, p[29:14]};
		rc = 17'h10000 - r;
		ns = '0;
		nc = '0;
		ns.t = p[30] ? rc : r;
		nc.t = p[30] ? r : rc;
		ns.neg = p[31];
		nc.neg = p[31] ^ p[30];
		ns.t2 = sq_step(ns.t);
		nc.t2 = sq_step(nc.t);
		ns7 = ps_s6;
		nc7 = pc_s6;
		ns7.inner = inner_step(ps_s6.t2);
		nc7.inner = inner_step(pc_s6.t2);
		ns8 = ps_s7;
		nc8 = pc_s7;
		ns8.mid = mid_step(ps_s7.t2, ps_s7.inner);
		nc8.mid = mid_step(pc_s7.t2, pc_s7.inner);
		pa = d_s9.dx * gs_s9;
		pb = d_s9.dy * gc_s9;
		dsum = pa + pb;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a1_s3 <= cx * HASH_MUL_A;
			cy_s3 <= y0 + {31'd0, OY};
			d_s3  <= d_in;
			a1_s4 <= a1_s3;
			b_s4  <= (cy_s3 ^ rot16(a1_s3)) * HASH_MUL_B;
			d_s4  <= d_s3;
			a3_s5 <= (a1_s4 ^ rot16(b_s4)) * seed;
			d_s5  <= d_s4;
			ps_s6 <= ns;
			pc_s6 <= nc;
			d_s6  <= d_s5;
			ps_s7 <= ns7;
			pc_s7 <= nc7;
			d_s7  <= d_s6;
			ps_s8 <= ns8;
			pc_s8 <= nc8;
			d_s8  <= d_s7;
			gs_s9 <= grad_step(ps_s8);
			gc_s9 <= grad_step(pc_s8);
			d_s9  <= d_s8;
			dot_s10 <= dsum[DOT_W+13:14];
		end
	end

	assign dot = dot_s10;

endmodule

// ===== rtl/core/fbm_octave.sv =====
module fbm_octave
	import fbm_pkg::*;
#(
	parameter int OCT        = 0,
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    en,
	input  cfg_t                    cfg,
	input  logic signed [31:0]      x_coord,
	input  logic signed [31:0]      y_coord,
	output logic signed [DOT_W-1:0] oct_val
);

	localparam int SHIFT = 24 - OCT;

	logic signed [57:0] mx_s1, my_s1;
	logic [31:0] x0_s2, y0_s2;
	logic [15:0] fx_s2, fy_s2, fx_s3, fy_s3, w2x_s3, w2y_s3;
	logic [33:0] fd_s4, fd_s5, fd_s6, fd_s7, fd_s8, fd_s9, fd_s10, fd_s11;
	logic signed [DOT_W-1:0] top_s11, bot_s11, val_s12;
	logic signed [DOT_W-1:0] dot00, dot10, dot01, dot11;

	logic signed [57:0] shx, shy;
	logic [47:0] px, py;

	always_comb begin
		shx = mx_s1 >>> SHIFT;
		shy = my_s1 >>> SHIFT;
		px = shx[47:0] + {17'd0, cfg.coord_offset};
		py = shy[47:0] + {17'd0, cfg.coord_offset};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1  <= x_coord * $signed({1'b0, cfg.scale_recip});
			my_s1  <= y_coord * $signed({1'b0, cfg.scale_recip});
			x0_s2  <= px[47:16];
			y0_s2  <= py[47:16];
			fx_s2  <= px[15:0];
			fy_s2  <= py[15:0];
			fx_s3  <= fx_s2;
			fy_s3  <= fy_s2;
			w2x_s3 <= fade_sq(fx_s2);
			w2y_s3 <= fade_sq(fy_s2);
			fd_s4  <= {fade_mul(w2x_s3, fx_s3), fade_mul(w2y_s3, fy_s3)};
			fd_s5  <= fd_s4;
			fd_s6  <= fd_s5;
			fd_s7  <= fd_s6;
			fd_s8  <= fd_s7;
			fd_s9  <= fd_s8;
			fd_s10 <= fd_s9;
			fd_s11 <= fd_s10;
			top_s11 <= blend(dot00, dot10, fd_s10[33:17]);
			bot_s11 <= blend(dot01, dot11, fd_s10[33:17]);
			val_s12 <= blend(top_s11, bot_s11, fd_s11[16:0]) >>> OCT;
		end
	end

	fbm_corner #(.ANGLE_BITS(ANGLE_BITS), .OX(1'b0), .OY(1'b0)) u_c00 (
		.clk(clk), .en(en), .seed(cfg.seed), .x0(x0_s2), .y0(y0_s2),
		.fx(fx_s2), .fy(fy_s2), .dot(dot00)
	);
	fbm_corner #(.ANGLE_BITS(ANGLE_BITS), .OX(1'b1), .OY(1'b0)) u_c10 (
		.clk(clk), .en(en), .seed(cfg.seed), .x0(x0_s2), .y0(y0_s2),
		.fx(fx_s2), .fy(fy_s2), .dot(dot10)
	);
	fbm_corner #(.ANGLE_BITS(ANGLE_BITS), .OX(1'b0), .OY(1'b1)) u_c01 (
		.clk(clk), .en(en), .seed(cfg.seed), .x0(x0_s2), .y0(y0_s2),
		.fx(fx_s2), .fy(fy_s2), .dot(dot01)
	);
	fbm_corner #(.ANGLE_BITS(ANGLE_BITS), .OX(1'b1), .OY(1'b1)) u_c11 (
		.clk(clk), .en(en), .seed(cfg.seed), .x0(x0_s2), .y0(y0_s2),
		.fx(fx_s2), .fy(fy_s2), .dot(dot11)
	);

	assign oct_val = val_s12;

endmodule

// ===== rtl/core/fbm_gradient_noise_2d.sv =====
// Fractal 2D gradient noise. One sample request (x_coord, y_coord, signed Q16.16) is
// accepted every cycle unless the output stalls, and its noise_value (signed Q1.14,
// saturated to [-1,1]) leaves the end of one fixed-depth pipeline; all octaves run in
// parallel lanes of it, each lane hashing its four lattice corners through three chained
// multiplies and a four-multiply sine polynomial. A stall on the output holds the whole pipeline.
// Registers: 0x0 scale_recip, 0x4 coord_offset, 0x8 seed, 0xC octave_count; write them
// only while no request is in flight.
module fbm_gradient_noise_2d
	import fbm_pkg::*;
#(
	parameter int MAX_OCTAVES = MAX_OCTAVES_DEF,
	parameter int ANGLE_BITS  = ANGLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	output logic               noise_valid,
	input  logic               noise_ready,
	output logic signed [15:0] noise_value
);

	localparam int LAT = 14;

	logic [24:0] scale_recip_q;
	logic [30:0] coord_offset_q;
	logic [31:0] seed_q;
	logic [3:0]  octave_count_q;
	logic [LAT-1:0] vld_q;
	logic en;
	cfg_t cfg;
	reg_idx_t idx;

	logic signed [DOT_W-1:0] lane_val [MAX_OCTAVES];
	logic signed [SUM_W-1:0] sum, sum_s13;
	logic signed [SUM_W+17:0] prod;
	logic signed [SUM_W-1:0] r;
	logic signed [15:0] noise_s14;

	assign idx = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign en = !vld_q[LAT-1] || noise_ready;
	assign sample_ready = en;
	assign noise_valid = vld_q[LAT-1];
	assign noise_value = noise_s14;

	always_comb begin
		cfg.scale_recip = scale_recip_q;
		cfg.coord_offset = coord_offset_q;
		cfg.seed = seed_q;
	end

	always_comb begin
		unique case (idx)
			REG_SCALE_RECIP:  prdata = {7'd0, scale_recip_q};
			REG_COORD_OFFSET: prdata = {1'b0, coord_offset_q};
			REG_SEED:         prdata = seed_q;
			REG_OCTAVE_COUNT: prdata = {28'd0, octave_count_q};
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_recip_q  <= SCALE_RECIP_RST;
			coord_offset_q <= COORD_OFFSET_RST;
			seed_q         <= SEED_RST;
			octave_count_q <= OCTAVE_COUNT_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (idx)
				REG_SCALE_RECIP:  scale_recip_q  <= pwdata[24:0];
				REG_COORD_OFFSET: coord_offset_q <= pwdata[30:0];
				REG_SEED:         seed_q         <= pwdata;
				REG_OCTAVE_COUNT: octave_count_q <= pwdata[3:0];
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], sample_valid};
		end
	end

	for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
		fbm_octave #(.OCT(i), .ANGLE_BITS(ANGLE_BITS)) u_oct (
			.clk(clk), .en(en), .cfg(cfg), .x_coord(x_coord), .y_coord(y_coord),
			.oct_val(lane_val[i])
		);
	end

	// octaves at or above the count drop out of the sum
	always_comb begin
		sum = '0;
		for (int i = 0; i < MAX_OCTAVES; i++) begin
			if (5'(i) < {1'b0, octave_count_q}) begin
				sum = sum + SUM_W'(lane_val[i]);
			end
		end
		prod = sum_s13 * CONTRAST_Q16;
		r = prod[SUM_W+17:18];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s13 <= sum;
			if (r > SUM_W'(ONE_Q14)) begin
				noise_s14 <= ONE_Q14;
			end else if (r < -SUM_W'(ONE_Q14)) begin
				noise_s14 <= -ONE_Q14;
			end else begin
				noise_s14 <= r[15:0];
			end
		end
	end

endmodule
